// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, default widths and the control word that travels
// alongside the data through the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS = 16;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
  localparam logic [OP_W-1:0] OP_MAG = 3'd5;

  typedef struct packed {
    logic valid;
    logic [OP_W-1:0] op;
  } cau_ctrl_t;

endpackage

// ===== rtl/cau_if.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cau_req_if
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] req_type;
  logic signed [DATA_WIDTH-1:0] x_re;
  logic signed [DATA_WIDTH-1:0] x_im;
  logic signed [DATA_WIDTH-1:0] y_re;
  logic signed [DATA_WIDTH-1:0] y_im;

  modport source (output valid, req_type, x_re, x_im, y_re, y_im, input ready);
  modport sink (input valid, req_type, x_re, x_im, y_re, y_im, output ready);
endinterface

interface cau_rsp_if
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] z_re;
  logic signed [DATA_WIDTH-1:0] z_im;
  logic overflow;
  logic div_by_zero;

  modport source (output valid, z_re, z_im, overflow, div_by_zero, input ready);
  modport sink (input valid, z_re, z_im, overflow, div_by_zero, output ready);
endinterface

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate and squared magnitude of
// complex fixed-point operands, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// The unit takes one request transaction every clock cycle while the response
// is not stalled, and returns one response transaction per request, in order.
// The divider resolves one quotient bit per pipeline stage for DATA_WIDTH + 1
// stages; every operation travels the same path. A stalled response
// freezes the whole pipeline, so nothing is lost or repeated.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  cau_req_if.sink req,
  cau_rsp_if.source rsp
);

  localparam int W = DATA_WIDTH;
  localparam int SW = 2 * W + 2;

  logic en;
  cau_ctrl_t in_ctrl;
  cau_ctrl_t front_ctrl;
  cau_ctrl_t div_ctrl;
  logic signed [SW-1:0] re_sum, im_sum, re_div, im_div;
  logic [2*W-1:0] den;
  logic [W:0] q_re, q_im;
  logic big_re, big_im, neg_re, neg_im, den_zero;

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;
  assign in_ctrl.valid = req.valid;
  assign in_ctrl.op = req.req_type;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_ctrl(in_ctrl),
    .x_re(req.x_re),
    .x_im(req.x_im),
    .y_re(req.y_re),
    .y_im(req.y_im),
    .out_ctrl(front_ctrl),
    .re_sum(re_sum),
    .im_sum(im_sum),
    .den(den)
  );

  cau_divider #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_divider (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_ctrl(front_ctrl),
    .re_sum(re_sum),
    .im_sum(im_sum),
    .den(den),
    .out_ctrl(div_ctrl),
    .re_out(re_div),
    .im_out(im_div),
    .q_re(q_re),
    .q_im(q_im),
    .big_re(big_re),
    .big_im(big_im),
    .neg_re(neg_re),
    .neg_im(neg_im),
    .den_zero(den_zero)
  );

  cau_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_ctrl(div_ctrl),
    .re_in(re_div),
    .im_in(im_div),
    .q_re(q_re),
    .q_im(q_im),
    .big_re(big_re),
    .big_im(big_im),
    .neg_re(neg_re),
    .neg_im(neg_im),
    .den_zero(den_zero),
    .valid(rsp.valid),
    .z_re(rsp.z_re),
    .z_im(rsp.z_im),
    .overflow(rsp.overflow),
    .div_by_zero(rsp.div_by_zero)
  );

endmodule

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Registers the operands, forms the partial products and combines them into
// the exact real part, imaginary part and squared divisor magnitude.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  cau_ctrl_t in_ctrl,
  input  logic signed [DATA_WIDTH-1:0] x_re,
  input  logic signed [DATA_WIDTH-1:0] x_im,
  input  logic signed [DATA_WIDTH-1:0] y_re,
  input  logic signed [DATA_WIDTH-1:0] y_im,
  output cau_ctrl_t out_ctrl,
  output logic signed [2*DATA_WIDTH+1:0] re_sum,
  output logic signed [2*DATA_WIDTH+1:0] im_sum,
  output logic [2*DATA_WIDTH-1:0] den
);

  localparam int W = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;

  cau_ctrl_t ctrl_a;
  cau_ctrl_t ctrl_b;
  logic signed [W-1:0] a_a, b_a, c_a, d_a;
  logic signed [W-1:0] a_b, b_b, c_b, d_b;
  logic signed [W-1:0] m1, m2;
  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [SW-1:0] re_next, im_next;
  logic [PW-1:0] den_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a <= '0;
      ctrl_b <= '0;
      out_ctrl <= '0;
    end else if (en) begin
      ctrl_a <= in_ctrl;
      ctrl_b <= ctrl_a;
      out_ctrl <= ctrl_b;
    end
  end

  assign m1 = (ctrl_a.op == OP_MAG) ? a_a : c_a;
  assign m2 = (ctrl_a.op == OP_MAG) ? b_a : d_a;

  always_ff @(posedge clk) begin
    if (en) begin
      a_a <= x_re;
      b_a <= x_im;
      c_a <= y_re;
      d_a <= y_im;
      a_b <= a_a;
      b_b <= b_a;
      c_b <= c_a;
      d_b <= d_a;
      p1 <= PW'(a_a) * PW'(m1);
      p2 <= PW'(b_a) * PW'(m2);
      p3 <= PW'(b_a) * PW'(c_a);
      p4 <= PW'(a_a) * PW'(d_a);
      p5 <= PW'(c_a) * PW'(c_a);
      p6 <= PW'(d_a) * PW'(d_a);
      re_sum <= re_next;
      im_sum <= im_next;
      den <= den_next;
    end
  end

  assign den_next = p5 + p6;

  always_comb begin
    re_next = '0;
    im_next = '0;
    case (ctrl_b.op)
      OP_ADD: begin
        re_next = SW'(a_b) + SW'(c_b);
        im_next = SW'(b_b) + SW'(d_b);
      end
      OP_SUB: begin
        re_next = SW'(a_b) - SW'(c_b);
        im_next = SW'(b_b) - SW'(d_b);
      end
      OP_MUL: begin
        re_next = SW'(p1) - SW'(p2);
        im_next = SW'(p3) + SW'(p4);
      end
      OP_DIV: begin
        re_next = SW'(p1) + SW'(p2);
        im_next = SW'(p3) - SW'(p4);
      end
      OP_CONJ: begin
        re_next = SW'(a_b);
        im_next = -SW'(b_b);
      end
      OP_MAG: begin
        re_next = SW'(p1) + SW'(p2);
      end
      default: begin
        re_next = '0;
        im_next = '0;
      end
    endcase
  end

endmodule

// ===== rtl/cau_divider.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage, for both result
// parts at once. Other operations ride along unchanged.
// ----------------------------------------------------------------------------
module cau_divider
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  cau_ctrl_t in_ctrl,
  input  logic signed [2*DATA_WIDTH+1:0] re_sum,
  input  logic signed [2*DATA_WIDTH+1:0] im_sum,
  input  logic [2*DATA_WIDTH-1:0] den,
  output cau_ctrl_t out_ctrl,
  output logic signed [2*DATA_WIDTH+1:0] re_out,
  output logic signed [2*DATA_WIDTH+1:0] im_out,
  output logic [DATA_WIDTH:0] q_re,
  output logic [DATA_WIDTH:0] q_im,
  output logic big_re,
  output logic big_im,
  output logic neg_re,
  output logic neg_im,
  output logic den_zero
);

  localparam int W = DATA_WIDTH;
  localparam int SW = 2 * W + 2;
  localparam int DW = 2 * W;
  localparam int QW = W + 1;
  localparam int NW = SW + FRAC_BITS;
  localparam int LW = DW + QW;
  localparam int CW = (NW > LW) ? NW : LW;
  localparam int NS = QW;

  cau_ctrl_t ctrl_s [NS+1];
  logic signed [SW-1:0] re_s [NS+1];
  logic signed [SW-1:0] im_s [NS+1];
  logic [CW-1:0] rr_s [NS+1];
  logic [CW-1:0] ri_s [NS+1];
  logic [QW-1:0] qr_s [NS+1];
  logic [QW-1:0] qi_s [NS+1];
  logic [DW-1:0] den_s [NS+1];
  logic big_r_s [NS+1];
  logic big_i_s [NS+1];
  logic neg_r_s [NS+1];
  logic neg_i_s [NS+1];
  logic dz_s [NS+1];

  logic [SW-1:0] mag_re, mag_im;
  logic [CW-1:0] num_re, num_im, lim;

  assign mag_re = re_sum[SW-1] ? SW'(-re_sum) : SW'(re_sum);
  assign mag_im = im_sum[SW-1] ? SW'(-im_sum) : SW'(im_sum);
  assign num_re = CW'(mag_re) << FRAC_BITS;
  assign num_im = CW'(mag_im) << FRAC_BITS;
  assign lim = CW'(den) << QW;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s[0] <= '0;
    end else if (en) begin
      ctrl_s[0] <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_s[0] <= re_sum;
      im_s[0] <= im_sum;
      rr_s[0] <= num_re;
      ri_s[0] <= num_im;
      qr_s[0] <= '0;
      qi_s[0] <= '0;
      den_s[0] <= den;
      big_r_s[0] <= num_re >= lim;
      big_i_s[0] <= num_im >= lim;
      neg_r_s[0] <= re_sum[SW-1];
      neg_i_s[0] <= im_sum[SW-1];
      dz_s[0] <= den == '0;
    end
  end

  for (genvar g = 1; g <= NS; g++) begin : g_stage
    localparam int BIT = QW - g;
    logic [CW-1:0] dsh;
    logic ge_r, ge_i;

    assign dsh = CW'(den_s[g-1]) << BIT;
    assign ge_r = rr_s[g-1] >= dsh;
    assign ge_i = ri_s[g-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_s[g] <= '0;
      end else if (en) begin
        ctrl_s[g] <= ctrl_s[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        re_s[g] <= re_s[g-1];
        im_s[g] <= im_s[g-1];
        rr_s[g] <= ge_r ? rr_s[g-1] - dsh : rr_s[g-1];
        ri_s[g] <= ge_i ? ri_s[g-1] - dsh : ri_s[g-1];
        qr_s[g] <= qr_s[g-1] | (QW'(ge_r) << BIT);
        qi_s[g] <= qi_s[g-1] | (QW'(ge_i) << BIT);
        den_s[g] <= den_s[g-1];
        big_r_s[g] <= big_r_s[g-1];
        big_i_s[g] <= big_i_s[g-1];
        neg_r_s[g] <= neg_r_s[g-1];
        neg_i_s[g] <= neg_i_s[g-1];
        dz_s[g] <= dz_s[g-1];
      end
    end
  end

  assign out_ctrl = ctrl_s[NS];
  assign re_out = re_s[NS];
  assign im_out = im_s[NS];
  assign q_re = qr_s[NS];
  assign q_im = qi_s[NS];
  assign big_re = big_r_s[NS];
  assign big_im = big_i_s[NS];
  assign neg_re = neg_r_s[NS];
  assign neg_im = neg_i_s[NS];
  assign den_zero = dz_s[NS];

endmodule

// ===== rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Drops the extra fraction bits of products, saturates both parts and holds
// the result in the output register until the transaction completes.
// ----------------------------------------------------------------------------
module cau_back
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  cau_ctrl_t in_ctrl,
  input  logic signed [2*DATA_WIDTH+1:0] re_in,
  input  logic signed [2*DATA_WIDTH+1:0] im_in,
  input  logic [DATA_WIDTH:0] q_re,
  input  logic [DATA_WIDTH:0] q_im,
  input  logic big_re,
  input  logic big_im,
  input  logic neg_re,
  input  logic neg_im,
  input  logic den_zero,
  output logic valid,
  output logic signed [DATA_WIDTH-1:0] z_re,
  output logic signed [DATA_WIDTH-1:0] z_im,
  output logic overflow,
  output logic div_by_zero
);

  localparam int W = DATA_WIDTH;
  localparam int SW = 2 * W + 2;
  localparam int QW = W + 1;
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [QW-1:0] QMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic [QW-1:0] QLIM = {2'b01, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
    if (v > MAXV) begin
      return {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      return {1'b1, MINV[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] quo_fn(input logic [QW-1:0] q, input logic big,
                                        input logic neg);
    logic [QW-1:0] nq;
    nq = ~q + QW'(1);
    if (!neg) begin
      if (big || q > QMAX) begin
        return {1'b1, MAXV[W-1:0]};
      end
      return {1'b0, q[W-1:0]};
    end
    if (big || q > QLIM) begin
      return {1'b1, MINV[W-1:0]};
    end
    return {1'b0, nq[W-1:0]};
  endfunction

  logic signed [SW-1:0] re_v, im_v;
  logic [W:0] re_s, im_s;
  logic [W-1:0] z_re_next, z_im_next;
  logic ovf_next, dz_next;

  always_comb begin
    re_v = re_in;
    im_v = im_in;
    if (in_ctrl.op == OP_MUL || in_ctrl.op == OP_MAG) begin
      re_v = re_in >>> FRAC_BITS;
      im_v = im_in >>> FRAC_BITS;
    end
    if (in_ctrl.op == OP_DIV) begin
      re_s = quo_fn(q_re, big_re, neg_re);
      im_s = quo_fn(q_im, big_im, neg_im);
    end else begin
      re_s = sat_fn(re_v);
      im_s = sat_fn(im_v);
    end
    z_re_next = re_s[W-1:0];
    z_im_next = im_s[W-1:0];
    ovf_next = re_s[W] | im_s[W];
    dz_next = 1'b0;
    if (in_ctrl.op == OP_DIV && den_zero) begin
      z_re_next = '0;
      z_im_next = '0;
      ovf_next = 1'b0;
      dz_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_re <= z_re_next;
      z_im <= z_im_next;
      overflow <= ovf_next;
      div_by_zero <= dz_next;
    end
  end

endmodule
